// ----- rtl/fspc_pkg.sv -----
// fspc_pkg: shared constants and types for the fan speed controller
// no dependencies
package fspc_pkg;

  localparam int FilterDepth   = 8;
  localparam int ControlPeriod = 10;

  localparam logic [15:0] GainPRst   = 16'd4096;
  localparam logic [15:0] GainIRst   = 16'd819;
  localparam logic [15:0] GainDRst   = 16'd41;
  localparam logic [14:0] IntLimRst  = 15'd2000;
  localparam logic [15:0] StartRst   = 16'd300;
  localparam logic [15:0] MaxDutyRst = 16'd1000;
  localparam logic [15:0] SpdLimRst  = 16'd6000;
  localparam logic [15:0] TimeoutRst = 16'd1000;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_EDGE = 2'd1,
    REQ_SET  = 2'd2,
    REQ_STOP = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_INT_LIMIT = 3'd3,
    REG_START     = 3'd4,
    REG_MAX_DUTY  = 3'd5,
    REG_SPEED_LIM = 3'd6,
    REG_TIMEOUT   = 3'd7
  } reg_idx_t;

endpackage

// ----- rtl/fspc_in_if.sv -----
// fspc_in_if, fspc_out_if, fspc_cfg_if: request channel interfaces
// no dependencies
interface fspc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] target_value;
  modport source  (output valid, req_type, target_value, input ready);
  modport sink    (input valid, req_type, target_value, output ready);
  modport monitor (input valid, ready, req_type, target_value);
endinterface

interface fspc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty;
  logic [15:0] measured_rpm;
  logic [15:0] goal_rpm;
  logic        running;
  modport source  (output valid, duty, measured_rpm, goal_rpm, running, input ready);
  modport sink    (input valid, duty, measured_rpm, goal_rpm, running, output ready);
  modport monitor (input valid, ready, duty, measured_rpm, goal_rpm, running);
endinterface

interface fspc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source  (output valid, index, data, input ready);
  modport sink    (input valid, index, data, output ready);
  modport monitor (input valid, ready, index, data);
endinterface

// ----- rtl/fan_speed_pid_controller.sv -----
// channel  dir  handshake      payload
// in_      in   valid/ready    req_type, target_value
// out_     out  valid/ready    duty, measured_rpm, goal_rpm, running
// cfg_     in   valid/ready    index, data
//
// one request at a time through a sequencer around a shared 16x19 multiplier
// and a restoring divider (one quotient bit a cycle)
// set, stop and an edge with no period go straight to the result; a tick checks
// timeout and period, maybe runs the pid; an edge with a period averages the ring
// rst_n is synchronous, active low; no clearing pass
// out_ holds a result until taken; in_ready is low from accept to result taken
// fan speed pid controller, top level
// uses fspc_pkg and the channel interfaces
module fan_speed_pid_controller #(
  parameter int FILTER_DEPTH   = fspc_pkg::FilterDepth,
  parameter int CONTROL_PERIOD = fspc_pkg::ControlPeriod
) (
  input  logic clk,
  input  logic rst_n,
  fspc_in_if.sink    in_ch,
  fspc_out_if.source out_ch,
  fspc_cfg_if.sink   cfg_ch
);

  localparam int PW = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int CW = $clog2(FILTER_DEPTH + 1);
  localparam int SW = 10 + CW;

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_DIV1, S_DIV2, S_MUL60, S_TO, S_PID0, S_MUL, S_PIDSUM,
    S_FIN, S_DONE
  } st_t;

  // config registers
  logic [15:0] gain_p_r, gain_i_r, gain_d_r, start_r, max_r, slim_r, tmo_r;
  logic [14:0] ilim_r;

  // block state
  logic [31:0] now_r, edge_r, act_r, ctl_r;
  logic [9:0]  ring_r [FILTER_DEPTH];
  logic [PW-1:0] ptr_r;
  logic [15:0] spd_r, goal_r, duty_r;
  logic        on_r;
  logic signed [16:0] acc_r;
  logic signed [17:0] eprev_r;

  // sequencer
  st_t st_r;
  logic [PW-1:0] idx_r;
  logic [SW-1:0] sum_r;
  logic [CW-1:0] cnt_r;
  logic [16:0] num_r, den_r, quo_r, rem_r;
  logic [4:0]  bit_r;
  logic [1:0]  term_r;
  logic signed [17:0] e_r;
  logic signed [22:0] pid_r;
  logic signed [19:0] op_r;
  logic        ovalid_r;

  assign in_ch.ready  = (st_r == S_IDLE) && !ovalid_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ovalid_r;
  assign out_ch.duty = duty_r;
  assign out_ch.measured_rpm = spd_r;
  assign out_ch.goal_rpm = goal_r;
  assign out_ch.running = on_r;

  // shared multiplier: gain times magnitude, truncated
  logic [15:0] mgain;
  logic [18:0] mmag;
  logic [34:0] mprod;
  always_comb begin
    case (term_r)
      2'd0:    mgain = gain_p_r;
      2'd1:    mgain = gain_i_r;
      default: mgain = gain_d_r;
    endcase
    mmag  = op_r[19] ? 19'(-op_r) : op_r[18:0];
    mprod = mgain * mmag;
  end
  logic signed [22:0] mterm;
  assign mterm = op_r[19] ? -$signed({1'b0, mprod[33:12]})
                          : $signed({1'b0, mprod[33:12]});

  // restoring divider step
  logic [17:0] dtrial;
  logic [16:0] rsh;
  assign rsh    = {rem_r[15:0], num_r[bit_r[3:0]]};
  assign dtrial = {1'b0, rsh} - {1'b0, den_r};

  logic [31:0] tnext;
  assign tnext = now_r + 32'd1;

  logic [15:0] clamp_tgt;
  assign clamp_tgt = (in_ch.target_value > slim_r) ? slim_r : in_ch.target_value;

  logic signed [18:0] acc_sum;
  assign acc_sum = 19'(acc_r) + 19'(e_r);

  logic [15:0] pid_duty;
  always_comb begin
    if (pid_r > $signed({7'd0, max_r}))        pid_duty = max_r;
    else if (pid_r < $signed({7'd0, start_r})) pid_duty = (start_r > max_r) ? max_r : start_r;
    else                                       pid_duty = pid_r[15:0];
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= fspc_pkg::GainPRst;  gain_i_r <= fspc_pkg::GainIRst;
      gain_d_r <= fspc_pkg::GainDRst;  ilim_r   <= fspc_pkg::IntLimRst;
      start_r  <= fspc_pkg::StartRst;  max_r    <= fspc_pkg::MaxDutyRst;
      slim_r   <= fspc_pkg::SpdLimRst; tmo_r    <= fspc_pkg::TimeoutRst;
    end else if (cfg_ch.valid) begin
      unique case (fspc_pkg::reg_idx_t'(cfg_ch.index))
        fspc_pkg::REG_GAIN_P:    gain_p_r <= cfg_ch.data;
        fspc_pkg::REG_GAIN_I:    gain_i_r <= cfg_ch.data;
        fspc_pkg::REG_GAIN_D:    gain_d_r <= cfg_ch.data;
        fspc_pkg::REG_INT_LIMIT: ilim_r   <= cfg_ch.data[14:0];
        fspc_pkg::REG_START:     start_r  <= cfg_ch.data;
        fspc_pkg::REG_MAX_DUTY:  max_r    <= cfg_ch.data;
        fspc_pkg::REG_SPEED_LIM: slim_r   <= cfg_ch.data;
        fspc_pkg::REG_TIMEOUT:   tmo_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ovalid_r <= 1'b0; term_r <= 2'd0;
      now_r <= '0; edge_r <= '0; act_r <= '0; ctl_r <= '0;
      for (int i = 0; i < FILTER_DEPTH; i++) ring_r[i] <= '0;
      ptr_r <= '0; spd_r <= '0; goal_r <= '0; duty_r <= '0; on_r <= 1'b0;
      acc_r <= '0; eprev_r <= '0;
    end else begin
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          unique case (fspc_pkg::req_t'(in_ch.req_type))
            fspc_pkg::REQ_TICK: begin
              now_r <= tnext;
              st_r  <= S_TO;
            end
            fspc_pkg::REQ_EDGE: begin
              edge_r <= now_r; act_r <= now_r;
              st_r <= S_DONE;
              if (edge_r != 0 && (now_r - edge_r) != 0 && (now_r - edge_r) < 32'd1000)
              begin
                ring_r[ptr_r] <= 10'(now_r - edge_r);
                ptr_r <= (32'(ptr_r) == FILTER_DEPTH - 1) ? '0 : ptr_r + 1'b1;
                idx_r <= '0; sum_r <= '0; cnt_r <= '0;
                st_r <= S_SUM;
              end
            end
            fspc_pkg::REQ_SET: begin
              goal_r <= clamp_tgt; acc_r <= '0;
              if (clamp_tgt == 0) begin duty_r <= '0; on_r <= 1'b0; end
              else if (!on_r) begin
                duty_r <= (start_r > max_r) ? max_r : start_r;
                on_r   <= ((start_r > max_r) ? max_r : start_r) != 0;
              end
              st_r <= S_DONE;
            end
            default: begin
              duty_r <= '0; on_r <= 1'b0; goal_r <= '0;
              acc_r <= '0; eprev_r <= '0;
              st_r <= S_DONE;
            end
          endcase
        end
        // walk the ring, one entry a cycle
        S_SUM: begin
          if (ring_r[idx_r] != 0) begin
            sum_r <= sum_r + SW'(ring_r[idx_r]);
            cnt_r <= cnt_r + 1'b1;
          end
          if (32'(idx_r) == FILTER_DEPTH - 1) st_r <= S_DIV1;
          idx_r <= idx_r + 1'b1;
        end
        // set up sum / count
        S_DIV1: begin
          num_r <= 17'(sum_r); den_r <= 17'(cnt_r);
          rem_r <= '0; quo_r <= '0; bit_r <= 5'd16;
          st_r <= S_DIV2;
        end
        // one quotient bit a cycle; two passes (avg, then 1000/avg)
        S_DIV2: begin
          if (bit_r == 5'd16) begin
            bit_r <= 5'd15;
            rem_r <= {16'd0, num_r[16]};
            if (den_r <= {16'd0, num_r[16]}) begin
              rem_r <= {16'd0, num_r[16]} - den_r; quo_r[16] <= 1'b1;
            end
          end else begin
            if (!dtrial[17]) begin rem_r <= dtrial[16:0]; quo_r[bit_r[3:0]] <= 1'b1; end
            else rem_r <= rsh;
            bit_r <= bit_r - 1'b1;
            if (bit_r == 5'd0) st_r <= S_MUL60;
          end
        end
        S_MUL60: begin
          if (den_r == 17'(cnt_r) && num_r == 17'(sum_r) && term_r != 2'd3) begin
            // first pass done: quo holds avg
            if (quo_r == 0) begin spd_r <= '0; st_r <= S_DONE; end
            else begin
              num_r <= 17'd1000; den_r <= quo_r; rem_r <= '0; quo_r <= '0;
              bit_r <= 5'd16; term_r <= 2'd3; st_r <= S_DIV2;
            end
          end else begin
            spd_r <= 16'(quo_r * 17'd60);
            term_r <= 2'd0;
            st_r <= S_DONE;
          end
        end
        // timeout, then control period
        S_TO: begin
          if (now_r - act_r > {16'd0, tmo_r}) begin
            edge_r <= '0; spd_r <= '0;
            for (int i = 0; i < FILTER_DEPTH; i++) ring_r[i] <= '0;
          end
          st_r <= S_DONE;
          if (now_r - ctl_r >= 32'(CONTROL_PERIOD)) begin
            ctl_r <= now_r;
            if (goal_r != 0) st_r <= S_PID0;
          end
        end
        S_PID0: begin
          e_r <= $signed({2'b0, goal_r}) - $signed({2'b0, spd_r});
          st_r <= S_PIDSUM; term_r <= 2'd3;
        end
        S_PIDSUM: begin
          // integral update then first product operand
          if (acc_sum > $signed({4'd0, ilim_r}))       acc_r <= $signed({2'b0, ilim_r});
          else if (acc_sum < -$signed({4'd0, ilim_r})) acc_r <= -$signed({2'b0, ilim_r});
          else                                         acc_r <= 17'(acc_sum);
          op_r <= 20'(e_r); term_r <= 2'd0; pid_r <= '0;
          st_r <= S_MUL;
        end
        // three products through one multiplier
        S_MUL: begin
          pid_r <= pid_r + mterm;
          term_r <= term_r + 1'b1;
          if (term_r == 2'd0) op_r <= 20'(acc_r);
          else if (term_r == 2'd1) op_r <= 20'(e_r) - 20'(eprev_r);
          else begin
            eprev_r <= e_r;
            term_r <= 2'd0;
            st_r <= S_FIN;
          end
        end
        S_FIN: begin
          duty_r <= pid_duty; on_r <= pid_duty != 0;
          st_r <= S_DONE;
        end
        default: begin
          ovalid_r <= 1'b1;
          st_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
